### hdl/scm_pkg.sv
// Shared types, codes and the key translation table of the keyboard converter.
`timescale 1ns / 1ps

package scm_pkg;

  // Key FIFO sizing
  localparam int FIFO_DEPTH = 32;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INQUIRY_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_REPLY     = 1'd1;
  localparam logic [7:0] RST_INQUIRY_TIMEOUT = 8'd6;
  localparam logic [7:0] RST_MODEL_REPLY     = 8'd9;

  // Input channel command field
  localparam logic [1:0] CMD_SCAN = 2'd0;
  localparam logic [1:0] CMD_HOST = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Host command bytes and replies
  localparam logic [7:0] HOST_INQUIRY = 8'h10;
  localparam logic [7:0] HOST_INSTANT = 8'h14;
  localparam logic [7:0] HOST_MODEL   = 8'h16;
  localparam logic [7:0] HOST_TEST    = 8'h36;
  localparam logic [7:0] NULL_REPLY   = 8'h7B;
  localparam logic [7:0] TEST_REPLY   = 8'h7D;

  // Scan bytes
  localparam logic [7:0] SCAN_E0        = 8'hE0;
  localparam logic [7:0] SCAN_E1        = 8'hE1;
  localparam logic [7:0] SCAN_RCTRL     = 8'h1D;
  localparam logic [7:0] SCAN_RCTRL_BRK = 8'h9D;
  localparam logic [7:0] SCAN_WIN       = 8'h5B;
  localparam logic [7:0] SCAN_WIN_BRK   = 8'hDB;
  localparam logic [7:0] MAP_WIN        = 8'h3B;
  localparam logic [7:0] MAP_WIN_BRK    = 8'hBB;
  localparam logic [7:0] SCAN_CAPS      = 8'h3A;
  localparam logic [7:0] SCAN_CAPS_BRK  = 8'hBA;
  localparam logic [6:0] LOW_NONE       = 7'd0;
  localparam logic [6:0] LOW_ESC        = 7'd1;
  localparam logic [6:0] LOW_GRAVE      = 7'd41;
  localparam logic [6:0] LOW_KP_STAR    = 7'd55;
  localparam logic [6:0] LOW_ALT        = 7'd56;
  localparam logic [6:0] LOW_LAST       = 7'd59;

  // Classified operation passed from front to back
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_SCAN    = 3'd1,
    OP_TICK    = 3'd2,
    OP_INQUIRY = 3'd3,
    OP_INSTANT = 3'd4,
    OP_MODEL   = 3'd5,
    OP_TEST    = 3'd6
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
  } op_t;

  // Prefix tracker states
  typedef enum logic [3:0] {
    PFX_NORMAL = 4'b0001,
    PFX_E0     = 4'b0010,
    PFX_E1     = 4'b0100,
    PFX_SKIP   = 4'b1000
  } pfx_state_t;

  // Set-1 make code (1..59) to host key code
  localparam logic [7:0] KEY_ROM [0:58] = '{
    8'h7B, 8'h25, 8'h27, 8'h29, 8'h2B, 8'h2F, 8'h2D, 8'h35, 8'h39, 8'h33,
    8'h3B, 8'h37, 8'h31, 8'h67, 8'h61, 8'h19, 8'h1B, 8'h1D, 8'h1F, 8'h23,
    8'h21, 8'h41, 8'h45, 8'h3F, 8'h47, 8'h43, 8'h3D, 8'h49, 8'h75, 8'h01,
    8'h03, 8'h05, 8'h07, 8'h0B, 8'h09, 8'h4D, 8'h51, 8'h4B, 8'h53, 8'h4F,
    8'h7B, 8'h71, 8'h55, 8'h0D, 8'h0F, 8'h11, 8'h13, 8'h17, 8'h5B, 8'h5D,
    8'h57, 8'h5F, 8'h59, 8'h71, 8'h7B, 8'h7B, 8'h63, 8'h73, 8'h6F
  };

  function automatic logic [7:0] key_lookup(input logic [6:0] low);
    logic [7:0] k;
    k = 8'h00;
    if (low != LOW_NONE && low <= LOW_LAST) begin
      k = KEY_ROM[6'(low - 7'd1)];
    end
    return k;
  endfunction

endpackage

### hdl/scm_in_if.sv
// Input channel: command kind and data byte with valid/ready handshake.
`timescale 1ns / 1ps

interface scm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

### hdl/scm_out_if.sv
// Result channel: reply byte with caps and queue status, valid/ready handshake.
`timescale 1ns / 1ps

interface scm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       caps_lock_on;
  logic [5:0] keys_queued;

  modport source (output valid, output reply_byte, output caps_lock_on,
                  output keys_queued, input ready);
  modport sink   (input valid, input reply_byte, input caps_lock_on,
                  input keys_queued, output ready);
endinterface

### hdl/scan_code_to_mac_keyboard_unit.sv
// Top level of the scan-code to host keyboard converter.
`timescale 1ns / 1ps

// The converter takes one transaction per clock on in_chan (scan byte, host
// command byte or timer tick) while out_chan does not stall and returns at
// most one reply on out_chan. A transaction is classified in a front
// register, passes through a two-entry operation queue and is carried out in
// the back stage, which updates the prefix tracker, caps latch and 32-entry
// key FIFO together and registers the reply; a transaction thus passes the
// front register, a queue slot and the reply register. With out_chan stalled
// behind a waiting reply, the front register and the queue take three more
// transactions before in_chan.ready drops.
// Registers are written on cfg_we: index 0 inquiry timeout in ticks, index 1
// model reply byte.

module scan_code_to_mac_keyboard_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [scm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_wdata,
  scm_in_if.sink                          in_chan,
  scm_out_if.source                       out_chan
);

  logic         front_valid;
  logic         front_ready;
  scm_pkg::op_t front_op;
  logic         back_valid;
  logic         back_ready;
  scm_pkg::op_t back_op;

  scm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .op_valid (front_valid),
    .op_ready (front_ready),
    .op       (front_op)
  );

  scm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_op    (front_op),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_op     (back_op)
  );

  scm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .op_valid  (back_valid),
    .op_ready  (back_ready),
    .op        (back_op),
    .out_chan  (out_chan)
  );

endmodule

### hdl/scm_front.sv
// Front stage: accepts input transactions and classifies them into operations.
`timescale 1ns / 1ps

module scm_front (
  input  logic          clk,
  input  logic          rst_n,
  scm_in_if.sink        in_chan,
  output logic          op_valid,
  input  logic          op_ready,
  output scm_pkg::op_t  op
);

  logic         valid_r;
  scm_pkg::op_t op_r;
  scm_pkg::op_t op_nxt;

  // Classify the incoming transaction
  always_comb begin
    op_nxt.data = in_chan.data_byte;
    op_nxt.kind = scm_pkg::OP_NONE;
    case (in_chan.command)
      scm_pkg::CMD_SCAN: op_nxt.kind = scm_pkg::OP_SCAN;
      scm_pkg::CMD_TICK: op_nxt.kind = scm_pkg::OP_TICK;
      scm_pkg::CMD_HOST: begin
        case (in_chan.data_byte)
          scm_pkg::HOST_INQUIRY: op_nxt.kind = scm_pkg::OP_INQUIRY;
          scm_pkg::HOST_INSTANT: op_nxt.kind = scm_pkg::OP_INSTANT;
          scm_pkg::HOST_MODEL:   op_nxt.kind = scm_pkg::OP_MODEL;
          scm_pkg::HOST_TEST:    op_nxt.kind = scm_pkg::OP_TEST;
          default:               op_nxt.kind = scm_pkg::OP_NONE;
        endcase
      end
      default: op_nxt.kind = scm_pkg::OP_NONE;
    endcase
  end

  assign in_chan.ready = !valid_r || op_ready;
  assign op_valid      = valid_r;
  assign op            = op_r;

  // Hold the classified operation until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      op_r <= op_nxt;
    end
  end

endmodule

### hdl/scm_queue.sv
// Two-entry operation queue between the front and back stages.
`timescale 1ns / 1ps

module scm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  scm_pkg::op_t  push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output scm_pkg::op_t  pop_op
);

  scm_pkg::op_t slot_r [0:1];
  logic         wr_r;
  logic         rd_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_op     = slot_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (do_pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_op;
    end
  end

endmodule

### hdl/scm_back.sv
// Back stage: prefix tracking, caps latch, key FIFO, host commands and replies.
`timescale 1ns / 1ps

module scm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [scm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_wdata,
  input  logic                            op_valid,
  output logic                            op_ready,
  input  scm_pkg::op_t                    op,
  scm_out_if.source                       out_chan
);

  localparam int PW = scm_pkg::PTR_W;
  localparam int CW = scm_pkg::CNT_W;

  // Configuration
  logic [7:0] timeout_r;
  logic [7:0] model_reply_r;

  // Converter state
  scm_pkg::pfx_state_t prefix_r, prefix_nxt;
  logic          caps_r, caps_nxt;
  logic [7:0]    key_store [0:scm_pkg::FIFO_DEPTH-1];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          awaiting_r, awaiting_nxt;
  logic [7:0]    wait_begin_r, wait_begin_nxt;
  logic [7:0]    tick_r, tick_nxt;

  // Result register
  logic       out_valid_r;
  logic [7:0] reply_r;
  logic       caps_out_r;
  logic [5:0] queued_r;

  // Scan decode
  scm_pkg::pfx_state_t scan_pfx;
  logic       scan_caps;
  logic       scan_push;
  logic [7:0] scan_key;
  logic [7:0] scan_byte;
  logic       scan_keep;
  logic [6:0] scan_low;

  logic       op_fire;
  logic       fifo_full;
  logic       do_push;
  logic       do_pop;
  logic       use_pop;
  logic       clear;
  logic       emit;
  logic [7:0] reply_nxt;
  logic [7:0] pop_val;
  logic [7:0] tick_inc;
  logic [7:0] elapsed;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    n = (p == PW'(scm_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  assign op_ready  = !out_valid_r || out_chan.ready;
  assign op_fire   = op_valid && op_ready;
  assign fifo_full = (count_r == CW'(scm_pkg::FIFO_DEPTH));
  assign tick_inc  = tick_r + 8'd1;
  assign elapsed   = tick_inc - wait_begin_r;

  // Decode a scan byte against the prefix state and caps latch
  always_comb begin
    scan_pfx  = scm_pkg::PFX_NORMAL;
    scan_keep = 1'b0;
    scan_byte = op.data;
    case (prefix_r)
      scm_pkg::PFX_SKIP: scan_keep = 1'b0;
      scm_pkg::PFX_E0: begin
        if (op.data == scm_pkg::SCAN_WIN) begin
          scan_byte = scm_pkg::MAP_WIN;
          scan_keep = 1'b1;
        end else if (op.data == scm_pkg::SCAN_WIN_BRK) begin
          scan_byte = scm_pkg::MAP_WIN_BRK;
          scan_keep = 1'b1;
        end else if (op.data == scm_pkg::SCAN_RCTRL || op.data == scm_pkg::SCAN_RCTRL_BRK) begin
          scan_keep = 1'b1;
        end
      end
      scm_pkg::PFX_E1: begin
        if (op.data == scm_pkg::SCAN_RCTRL || op.data == scm_pkg::SCAN_RCTRL_BRK) begin
          scan_pfx = scm_pkg::PFX_SKIP;
        end else if (op.data == scm_pkg::SCAN_E0) begin
          scan_pfx = scm_pkg::PFX_E0;
        end else begin
          scan_keep = 1'b1;
        end
      end
      scm_pkg::PFX_NORMAL: begin
        if (op.data == scm_pkg::SCAN_E1) begin
          scan_pfx = scm_pkg::PFX_E1;
        end else if (op.data == scm_pkg::SCAN_E0) begin
          scan_pfx = scm_pkg::PFX_E0;
        end else begin
          scan_keep = 1'b1;
        end
      end
      default: scan_keep = 1'b0;
    endcase

    // Drop caps break; toggle the latch on caps make
    scan_caps = caps_r;
    if (scan_keep && scan_byte == scm_pkg::SCAN_CAPS_BRK) begin
      scan_keep = 1'b0;
    end
    if (scan_keep && scan_byte == scm_pkg::SCAN_CAPS) begin
      scan_caps = ~caps_r;
      scan_byte = scan_caps ? scm_pkg::SCAN_CAPS : scm_pkg::SCAN_CAPS_BRK;
    end

    scan_low  = scan_byte[6:0];
    scan_push = scan_keep
             && scan_low != scm_pkg::LOW_NONE && scan_low != scm_pkg::LOW_ESC
             && scan_low != scm_pkg::LOW_GRAVE && scan_low != scm_pkg::LOW_KP_STAR
             && scan_low != scm_pkg::LOW_ALT && scan_low <= scm_pkg::LOW_LAST;
    scan_key  = scm_pkg::key_lookup(scan_low) | {scan_byte[7], 7'd0};
  end

  // Oldest key, with bypass of a key pushed into an empty FIFO
  assign pop_val = (count_r != '0) ? key_store[rd_ptr_r]
                 : (do_push ? scan_key : scm_pkg::NULL_REPLY);

  // Carry out one operation
  always_comb begin
    prefix_nxt     = prefix_r;
    caps_nxt       = caps_r;
    awaiting_nxt   = awaiting_r;
    wait_begin_nxt = wait_begin_r;
    tick_nxt       = tick_r;
    do_push        = 1'b0;
    do_pop         = 1'b0;
    use_pop        = 1'b0;
    clear          = 1'b0;
    emit           = 1'b0;
    reply_nxt      = scm_pkg::TEST_REPLY;
    if (op_fire) begin
      case (op.kind)
        scm_pkg::OP_SCAN: begin
          prefix_nxt = scan_pfx;
          caps_nxt   = scan_caps;
          do_push    = scan_push && !fifo_full;
          if (awaiting_r && (count_r != '0 || do_push)) begin
            awaiting_nxt = 1'b0;
            do_pop       = 1'b1;
            use_pop      = 1'b1;
            emit         = 1'b1;
          end
        end
        scm_pkg::OP_TICK: begin
          tick_nxt = tick_inc;
          if (awaiting_r && elapsed >= timeout_r) begin
            awaiting_nxt = 1'b0;
            do_pop       = (count_r != '0);
            use_pop      = 1'b1;
            emit         = 1'b1;
          end
        end
        scm_pkg::OP_INQUIRY: begin
          if (!awaiting_r) begin
            if (count_r != '0 || timeout_r == 8'd0) begin
              do_pop  = (count_r != '0);
              use_pop = 1'b1;
              emit    = 1'b1;
            end else begin
              awaiting_nxt   = 1'b1;
              wait_begin_nxt = tick_r;
            end
          end
        end
        scm_pkg::OP_INSTANT: begin
          if (!awaiting_r) begin
            do_pop  = (count_r != '0);
            use_pop = 1'b1;
            emit    = 1'b1;
          end
        end
        scm_pkg::OP_MODEL: begin
          if (!awaiting_r) begin
            clear      = 1'b1;
            caps_nxt   = 1'b0;
            prefix_nxt = scm_pkg::PFX_NORMAL;
            reply_nxt  = model_reply_r;
            emit       = 1'b1;
          end
        end
        scm_pkg::OP_TEST: begin
          if (!awaiting_r) begin
            reply_nxt = scm_pkg::TEST_REPLY;
            emit      = 1'b1;
          end
        end
        default: emit = 1'b0;
      endcase
    end
    if (use_pop) reply_nxt = pop_val;
  end

  // Next FIFO pointers and occupancy
  always_comb begin
    if (clear) begin
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
      count_nxt  = '0;
    end else begin
      wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
      rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
      count_nxt  = count_r + CW'(do_push) - CW'(do_pop);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= scm_pkg::RST_INQUIRY_TIMEOUT;
      model_reply_r <= scm_pkg::RST_MODEL_REPLY;
    end else if (cfg_we) begin
      case (cfg_index)
        scm_pkg::CFG_INQUIRY_TIMEOUT: timeout_r     <= cfg_wdata;
        scm_pkg::CFG_MODEL_REPLY:     model_reply_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Update converter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r     <= scm_pkg::PFX_NORMAL;
      caps_r       <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
      awaiting_r   <= 1'b0;
      wait_begin_r <= 8'd0;
      tick_r       <= 8'd0;
    end else begin
      prefix_r     <= prefix_nxt;
      caps_r       <= caps_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      count_r      <= count_nxt;
      awaiting_r   <= awaiting_nxt;
      wait_begin_r <= wait_begin_nxt;
      tick_r       <= tick_nxt;
    end
  end

  // Write the key store
  always_ff @(posedge clk) begin
    if (do_push) begin
      key_store[wr_ptr_r] <= scan_key;
    end
  end

  // Hold the reply until the host side takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      reply_r    <= reply_nxt;
      caps_out_r <= caps_nxt;
      queued_r   <= 6'(count_nxt);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.reply_byte   = reply_r;
  assign out_chan.caps_lock_on = caps_out_r;
  assign out_chan.keys_queued  = queued_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(scm_pkg::FIFO_DEPTH))
    else $error("key FIFO occupancy above depth");

  a_wait_empty: assert property (@(posedge clk) disable iff (!rst_n)
    awaiting_r |-> (count_r == '0))
    else $error("inquiry waiting while keys are queued");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CW'(scm_pkg::FIFO_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("FIFO pointers disagree with occupancy");

  a_model_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (op_fire && op.kind == scm_pkg::OP_MODEL && !awaiting_r)
      |=> (count_r == '0 && !caps_r && prefix_r == scm_pkg::PFX_NORMAL))
    else $error("model command did not clear converter state");

endmodule

### verif/tb_scan_code_to_mac_keyboard_unit.sv
// Self-checking testbench of the scan-code to host keyboard converter.
`timescale 1ns / 1ps

module tb_scan_code_to_mac_keyboard_unit;

  // Timing and run control
  localparam int LONG_HOLD      = 150;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_PRINTED    = 100;
  localparam int KEY_SLOTS      = 32;

  // Command field value the block must ignore
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  // Configuration values after reset
  localparam logic [7:0] TIMEOUT_AT_RESET = 8'd6;
  localparam logic [7:0] MODEL_AT_RESET   = 8'd9;

  // Host command bytes and fixed replies
  localparam logic [7:0] CODE_INQUIRY = 8'h10;
  localparam logic [7:0] CODE_INSTANT = 8'h14;
  localparam logic [7:0] CODE_MODEL   = 8'h16;
  localparam logic [7:0] CODE_TEST    = 8'h36;
  localparam logic [7:0] REPLY_NULL   = 8'h7B;
  localparam logic [7:0] REPLY_TEST   = 8'h7D;

  // Scan bytes with special handling
  localparam logic [7:0] SC_E0          = 8'hE0;
  localparam logic [7:0] SC_E1          = 8'hE1;
  localparam logic [7:0] SC_RCTRL       = 8'h1D;
  localparam logic [7:0] SC_RCTRL_BRK   = 8'h9D;
  localparam logic [7:0] SC_WIN         = 8'h5B;
  localparam logic [7:0] SC_WIN_BRK     = 8'hDB;
  localparam logic [7:0] WIN_MAPPED     = 8'h3B;
  localparam logic [7:0] WIN_MAPPED_BRK = 8'hBB;
  localparam logic [7:0] SC_CAPS        = 8'h3A;
  localparam logic [7:0] SC_CAPS_BRK    = 8'hBA;
  localparam logic [7:0] SC_NUMLOCK     = 8'h45;
  localparam logic [7:0] SC_NUMLOCK_BRK = 8'hC5;
  localparam logic [7:0] SC_KEY_A       = 8'h1E;
  localparam logic [7:0] BREAK_BIT      = 8'h80;

  // Make codes without a host key, and the last make code with one
  localparam logic [6:0] LOW_NONE    = 7'd0;
  localparam logic [6:0] LOW_ESC     = 7'd1;
  localparam logic [6:0] LOW_GRAVE   = 7'd41;
  localparam logic [6:0] LOW_KP_STAR = 7'd55;
  localparam logic [6:0] LOW_ALT     = 7'd56;
  localparam logic [6:0] LOW_LAST    = 7'd59;

  // Host key code for set-1 make codes 1..59
  localparam logic [7:0] KEY_MAP [0:58] = '{
    8'h7B, 8'h25, 8'h27, 8'h29, 8'h2B, 8'h2F, 8'h2D, 8'h35, 8'h39, 8'h33,
    8'h3B, 8'h37, 8'h31, 8'h67, 8'h61, 8'h19, 8'h1B, 8'h1D, 8'h1F, 8'h23,
    8'h21, 8'h41, 8'h45, 8'h3F, 8'h47, 8'h43, 8'h3D, 8'h49, 8'h75, 8'h01,
    8'h03, 8'h05, 8'h07, 8'h0B, 8'h09, 8'h4D, 8'h51, 8'h4B, 8'h53, 8'h4F,
    8'h7B, 8'h71, 8'h55, 8'h0D, 8'h0F, 8'h11, 8'h13, 8'h17, 8'h5B, 8'h5D,
    8'h57, 8'h5F, 8'h59, 8'h71, 8'h7B, 8'h7B, 8'h63, 8'h73, 8'h6F
  };

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } conv_item_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       caps_lock_on;
    logic [5:0] keys_queued;
  } conv_reply_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [scm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_wdata;

  scm_in_if  in_chan ();
  scm_out_if out_chan ();

  scan_code_to_mac_keyboard_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // Stimulus and expectation stores
  conv_item_t  input_items[$];
  conv_reply_t expected_replies[$];
  int          items_added;
  int          mismatches;
  int          hold_req;
  int          hold_seen;
  int          send_gap;
  int          send_calm;
  int          recv_stall;
  int          recv_calm;
  int          idle_cycles;

  // Converter state as predicted
  scm_pkg::pfx_state_t prefix;
  logic       caps_on;
  logic [7:0] key_mem [0:KEY_SLOTS-1];
  int         wr_ptr;
  int         rd_ptr;
  int         key_count;
  logic       awaiting;
  logic [7:0] wait_start;
  logic [7:0] tick_cnt;
  logic [7:0] timeout_reg;
  logic [7:0] model_reg;

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    // keep the log short when things go badly wrong
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
  endtask

  function automatic void store_key(input logic [7:0] k);
    if (key_count >= KEY_SLOTS) begin
      return;
    end
    key_mem[5'(wr_ptr)] = k;
    wr_ptr = (wr_ptr + 1) % KEY_SLOTS;
    key_count++;
  endfunction

  function automatic logic [7:0] fetch_key();
    logic [7:0] k;
    if (key_count == 0) begin
      return REPLY_NULL;
    end
    k = key_mem[5'(rd_ptr)];
    rd_ptr = (rd_ptr + 1) % KEY_SLOTS;
    key_count--;
    return k;
  endfunction

  function automatic void queue_reply(input logic [7:0] rb);
    conv_reply_t r;
    r.reply_byte   = rb;
    r.caps_lock_on = caps_on;
    r.keys_queued  = 6'(key_count);
    expected_replies.push_back(r);
  endfunction

  // Prefix tracking, caps latch and key translation for one scan byte
  function automatic void take_scan_byte(input logic [7:0] b);
    scm_pkg::pfx_state_t mode;
    logic [7:0] code;
    logic [6:0] low;
    mode   = prefix;
    prefix = scm_pkg::PFX_NORMAL;
    code   = b;
    if (mode == scm_pkg::PFX_SKIP) begin
      return;
    end
    if (mode == scm_pkg::PFX_E0) begin
      // only right ctrl and the windows key survive an E0 prefix
      if (b == SC_WIN) begin
        code = WIN_MAPPED;
      end else if (b == SC_WIN_BRK) begin
        code = WIN_MAPPED_BRK;
      end else if (b != SC_RCTRL && b != SC_RCTRL_BRK) begin
        return;
      end
    end else if (mode == scm_pkg::PFX_E1) begin
      if (b == SC_RCTRL || b == SC_RCTRL_BRK) begin
        prefix = scm_pkg::PFX_SKIP;
        return;
      end
      if (b == SC_E0) begin
        prefix = scm_pkg::PFX_E0;
        return;
      end
    end else begin
      if (b == SC_E1) begin
        prefix = scm_pkg::PFX_E1;
        return;
      end
      if (b == SC_E0) begin
        prefix = scm_pkg::PFX_E0;
        return;
      end
    end
    // caps lock: make toggles, break is dropped
    if (code == SC_CAPS_BRK) begin
      return;
    end
    if (code == SC_CAPS) begin
      caps_on = ~caps_on;
      code    = caps_on ? SC_CAPS : SC_CAPS_BRK;
    end
    low = code[6:0];
    if (low == LOW_NONE || low == LOW_ESC || low == LOW_GRAVE || low == LOW_KP_STAR ||
        low == LOW_ALT || low > LOW_LAST) begin
      return;
    end
    store_key(KEY_MAP[6'(low - 7'd1)] | (code & BREAK_BIT));
  endfunction

  // Update the predicted state for one accepted transaction
  function automatic void convert_item(input logic [1:0] command, input logic [7:0] d);
    logic [7:0] elapsed;
    case (command)
      scm_pkg::CMD_SCAN: begin
        take_scan_byte(d);
        if (awaiting && key_count > 0) begin
          awaiting = 1'b0;
          queue_reply(fetch_key());
        end
      end
      scm_pkg::CMD_TICK: begin
        tick_cnt = tick_cnt + 8'd1;
        elapsed  = tick_cnt - wait_start;
        if (awaiting && elapsed >= timeout_reg) begin
          awaiting = 1'b0;
          queue_reply(fetch_key());
        end
      end
      scm_pkg::CMD_HOST: begin
        // commands are ignored while an inquiry waits
        if (!awaiting) begin
          case (d)
            CODE_INQUIRY: begin
              if (key_count > 0 || timeout_reg == 8'd0) begin
                queue_reply(fetch_key());
              end else begin
                awaiting   = 1'b1;
                wait_start = tick_cnt;
              end
            end
            CODE_INSTANT: queue_reply(fetch_key());
            CODE_MODEL: begin
              wr_ptr    = 0;
              rd_ptr    = 0;
              key_count = 0;
              caps_on   = 1'b0;
              prefix    = scm_pkg::PFX_NORMAL;
              queue_reply(model_reg);
            end
            CODE_TEST: queue_reply(REPLY_TEST);
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_reply(input logic [7:0] rb, input logic caps, input logic [5:0] q);
    conv_reply_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch($sformatf("reply %02h with none expected", rb));
    end else begin
      want = expected_replies.pop_front();
      if (rb !== want.reply_byte) begin
        report_mismatch($sformatf("reply_byte %02h, want %02h", rb, want.reply_byte));
      end
      if (caps !== want.caps_lock_on) begin
        report_mismatch($sformatf("caps_lock_on %0b, want %0b", caps, want.caps_lock_on));
      end
      if (q !== want.keys_queued) begin
        report_mismatch($sformatf("keys_queued %0d, want %0d", q, want.keys_queued));
      end
    end
  endtask

  // Input driver: offer queued items with random gaps
  always @(posedge clk) begin
    logic       offer;
    conv_item_t cur;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_gap  = 0;
      send_calm = 0;
    end else begin
      offer = in_chan.valid;
      if (in_chan.valid && in_chan.ready) begin
        convert_item(in_chan.command, in_chan.data_byte);
        offer = 1'b0;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          send_calm = $urandom_range(10, 40);
          send_gap  = 0;
        end else begin
          send_gap = $urandom_range(0, 10);
        end
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (input_items.size() > 0) begin
          cur = input_items.pop_front();
          offer = 1'b1;
          in_chan.command   <= cur.command;
          in_chan.data_byte <= cur.data_byte;
        end
      end
      in_chan.valid <= offer;
    end
  end

  // Reply monitor: check each transaction, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      recv_stall = 0;
      recv_calm  = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        check_reply(out_chan.reply_byte, out_chan.caps_lock_on, out_chan.keys_queued);
        if (recv_calm > 0) begin
          recv_calm--;
          recv_stall = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          recv_calm  = $urandom_range(10, 40);
          recv_stall = 0;
        end else begin
          recv_stall = $urandom_range(0, 10);
        end
      end
      // long back-pressure on request
      if (hold_seen != hold_req) begin
        hold_seen  = hold_req;
        recv_stall = LONG_HOLD;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void add_item(input logic [1:0] command, input logic [7:0] d);
    conv_item_t it;
    it.command   = command;
    it.data_byte = d;
    input_items.push_back(it);
    items_added++;
  endfunction

  function automatic logic [7:0] valid_make_code();
    int unsigned c;
    c = $urandom_range(2, 59);
    while (c == 41 || c == 55 || c == 56 || c == 58) begin
      c = $urandom_range(2, 59);
    end
    return 8'(c);
  endfunction

  // Mostly well-formed keyboard and host traffic, some noise
  function automatic void add_random_sequence();
    int unsigned pick;
    int unsigned sel;
    logic [7:0]  code;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      code = valid_make_code();
      add_item(scm_pkg::CMD_SCAN, code);
      if ($urandom_range(0, 9) < 4) begin
        add_item(scm_pkg::CMD_SCAN, code | BREAK_BIT);
      end
    end else if (pick < 29) begin
      add_item(scm_pkg::CMD_SCAN, SC_E0);
      sel = $urandom_range(0, 4);
      case (sel)
        0: add_item(scm_pkg::CMD_SCAN, SC_RCTRL);
        1: add_item(scm_pkg::CMD_SCAN, SC_RCTRL_BRK);
        2: add_item(scm_pkg::CMD_SCAN, SC_WIN);
        3: add_item(scm_pkg::CMD_SCAN, SC_WIN_BRK);
        default: add_item(scm_pkg::CMD_SCAN, 8'($urandom));
      endcase
    end else if (pick < 33) begin
      add_item(scm_pkg::CMD_SCAN, SC_E1);
      if ($urandom_range(0, 1) == 1) begin
        add_item(scm_pkg::CMD_SCAN, SC_RCTRL);
        add_item(scm_pkg::CMD_SCAN, SC_NUMLOCK);
        add_item(scm_pkg::CMD_SCAN, SC_E1);
        add_item(scm_pkg::CMD_SCAN, SC_RCTRL_BRK);
        add_item(scm_pkg::CMD_SCAN, SC_NUMLOCK_BRK);
      end else begin
        add_item(scm_pkg::CMD_SCAN, 8'($urandom));
      end
    end else if (pick < 36) begin
      add_item(scm_pkg::CMD_SCAN, SC_CAPS);
      if ($urandom_range(0, 1) == 1) begin
        add_item(scm_pkg::CMD_SCAN, SC_CAPS_BRK);
      end
    end else if (pick < 77) begin
      sel = $urandom_range(0, 19);
      if (sel < 7) begin
        add_item(scm_pkg::CMD_HOST, CODE_INQUIRY);
      end else if (sel < 14) begin
        add_item(scm_pkg::CMD_HOST, CODE_INSTANT);
      end else if (sel < 16) begin
        add_item(scm_pkg::CMD_HOST, CODE_TEST);
      end else if (sel < 17) begin
        add_item(scm_pkg::CMD_HOST, CODE_MODEL);
      end else begin
        add_item(scm_pkg::CMD_HOST, 8'($urandom));
      end
    end else if (pick < 89) begin
      repeat ($urandom_range(1, 6)) begin
        add_item(scm_pkg::CMD_TICK, 8'($urandom));
      end
    end else begin
      add_item(2'($urandom_range(0, 3)), 8'($urandom));
    end
  endfunction

  function automatic void add_random_items(input int count);
    int first;
    first = items_added;
    while (items_added - first < count) begin
      add_random_sequence();
    end
  endfunction

  // Wait until every item is taken and every reply has come, then settle
  task automatic drain_replies();
    @(negedge clk);
    while (input_items.size() != 0 || in_chan.valid || expected_replies.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leave the block idle with no inquiry pending
  task automatic close_phase();
    drain_replies();
    while (awaiting) begin
      add_item(scm_pkg::CMD_SCAN, SC_KEY_A);
      drain_replies();
    end
  endtask

  task automatic write_reg(input logic [scm_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == scm_pkg::CFG_INQUIRY_TIMEOUT) begin
      timeout_reg = value;
    end else begin
      model_reg = value;
    end
    @(negedge clk);
  endtask

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = scm_pkg::CFG_INQUIRY_TIMEOUT;
    cfg_wdata          = 8'd0;
    in_chan.valid      = 1'b0;
    in_chan.command    = scm_pkg::CMD_SCAN;
    in_chan.data_byte  = 8'd0;
    out_chan.ready     = 1'b0;
    items_added        = 0;
    mismatches         = 0;
    hold_req           = 0;
    hold_seen          = 0;
    idle_cycles        = 0;
    prefix             = scm_pkg::PFX_NORMAL;
    caps_on            = 1'b0;
    wr_ptr             = 0;
    rd_ptr             = 0;
    key_count          = 0;
    awaiting           = 1'b0;
    wait_start         = 8'd0;
    tick_cnt           = 8'd0;
    timeout_reg        = TIMEOUT_AT_RESET;
    model_reg          = MODEL_AT_RESET;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: replies, key ranges, caps, prefixes, odd commands, timeout
    add_item(scm_pkg::CMD_HOST, CODE_TEST);
    add_item(scm_pkg::CMD_HOST, CODE_INSTANT);
    add_item(scm_pkg::CMD_SCAN, 8'h02);
    add_item(scm_pkg::CMD_SCAN, 8'h82);
    add_item(scm_pkg::CMD_SCAN, 8'h3B);
    add_item(scm_pkg::CMD_SCAN, 8'h00);
    add_item(scm_pkg::CMD_SCAN, 8'hFF);
    add_item(scm_pkg::CMD_SCAN, SC_CAPS);
    add_item(scm_pkg::CMD_SCAN, SC_CAPS_BRK);
    add_item(scm_pkg::CMD_SCAN, SC_CAPS);
    add_item(scm_pkg::CMD_SCAN, SC_E0);
    add_item(scm_pkg::CMD_SCAN, SC_WIN);
    add_item(scm_pkg::CMD_SCAN, SC_E0);
    add_item(scm_pkg::CMD_SCAN, SC_RCTRL_BRK);
    add_item(scm_pkg::CMD_SCAN, SC_E0);
    add_item(scm_pkg::CMD_SCAN, SC_E1);
    add_item(scm_pkg::CMD_SCAN, SC_E1);
    add_item(scm_pkg::CMD_SCAN, SC_RCTRL);
    add_item(scm_pkg::CMD_SCAN, SC_NUMLOCK);
    add_item(scm_pkg::CMD_SCAN, SC_E1);
    add_item(scm_pkg::CMD_SCAN, 8'h47);
    add_item(scm_pkg::CMD_HOST, CODE_INQUIRY);
    add_item(scm_pkg::CMD_HOST, 8'h00);
    add_item(scm_pkg::CMD_HOST, 8'hFF);
    add_item(CMD_RESERVED, 8'hFF);
    add_item(scm_pkg::CMD_HOST, CODE_MODEL);
    add_item(scm_pkg::CMD_HOST, CODE_INQUIRY);
    add_item(scm_pkg::CMD_HOST, CODE_TEST);
    repeat (6) add_item(scm_pkg::CMD_TICK, 8'h00);
    close_phase();
    add_random_items(90);
    close_phase();

    // Shortest nonzero timeout, lowest model byte
    write_reg(scm_pkg::CFG_INQUIRY_TIMEOUT, 8'd1);
    write_reg(scm_pkg::CFG_MODEL_REPLY, 8'h00);
    add_random_items(90);
    close_phase();

    // Longest timeout, highest model byte; fill the key FIFO past full
    write_reg(scm_pkg::CFG_INQUIRY_TIMEOUT, 8'd255);
    write_reg(scm_pkg::CFG_MODEL_REPLY, 8'hFF);
    add_item(scm_pkg::CMD_HOST, CODE_MODEL);
    repeat (36) add_item(scm_pkg::CMD_SCAN, valid_make_code());
    close_phase();
    // hold off replies while a stream of pops backs up the block
    hold_req++;
    repeat (30) add_item(scm_pkg::CMD_HOST, CODE_INSTANT);
    repeat (6) add_item(scm_pkg::CMD_HOST, CODE_TEST);
    close_phase();
    add_random_items(80);
    close_phase();

    // Zero timeout: inquiry on an empty FIFO answers at once
    write_reg(scm_pkg::CFG_INQUIRY_TIMEOUT, 8'd0);
    write_reg(scm_pkg::CFG_MODEL_REPLY, 8'($urandom));
    add_item(scm_pkg::CMD_HOST, CODE_MODEL);
    add_item(scm_pkg::CMD_HOST, CODE_INQUIRY);
    add_item(scm_pkg::CMD_TICK, 8'hFF);
    add_random_items(80);
    close_phase();

    // Mid-range settings
    write_reg(scm_pkg::CFG_INQUIRY_TIMEOUT, 8'($urandom_range(2, 12)));
    write_reg(scm_pkg::CFG_MODEL_REPLY, 8'($urandom));
    add_random_items(100);
    close_phase();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
